// File: design/dpvs_pkg.sv
// ----------------------------------------------------------------------------
// dpvs_pkg
// Shared types, constants and the valve pattern table of the dual pump
// valve sequencer.
// ----------------------------------------------------------------------------
package dpvs_pkg;

	localparam int unsigned TICK_W     = 16;
	localparam int unsigned HOLD_CNT_W = 12;
	localparam int unsigned VALVE_W    = 9;
	localparam int unsigned STEP_W     = 3;
	localparam int unsigned RATE_W     = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Rate division: floor((300000 + 2*T) / (5*T)), 19-bit operands.
	localparam int unsigned DIV_W      = 19;
	localparam int unsigned DIV_STEPS  = DIV_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam logic [DIV_W-1:0] RATE_NUM_BASE = DIV_W'(300000);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EJECT_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 2'd2;

	localparam logic [TICK_W-1:0]     BEAT_PERIOD_RST = 16'd1000;
	localparam logic [HOLD_CNT_W-1:0] EJECT_TICKS_RST = 12'd15;
	localparam logic [HOLD_CNT_W-1:0] DELAY_TICKS_RST = 12'd10;

	// Step codes.
	localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_FILL  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_EJECT = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DELAY = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SAC1  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_SAC2  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_FLUSH = 3'd6;
	localparam logic [STEP_W-1:0] STEP_LAST  = 3'd7;

	localparam logic [HOLD_CNT_W-1:0] SHORT_STEP_LIMIT = 12'd5;
	localparam logic [HOLD_CNT_W-1:0] FLUSH_STEP_LIMIT = 12'd15;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic load_out;
	} dpvs_cmd_t;

	typedef struct packed {
		logic period_end;
	} dpvs_status_t;

	typedef struct packed {
		logic [STEP_W-1:0]     phase;
		logic [HOLD_CNT_W-1:0] count;
		logic [VALVE_W-1:0]    pattern;
	} pump_t;

	function automatic logic [VALVE_W-1:0] step_pattern(input logic [STEP_W-1:0] step);
		logic [VALVE_W-1:0] pat;
		case (step)
			STEP_FILL:  pat = 9'h00B;
			STEP_EJECT: pat = 9'h1FB;
			STEP_DELAY: pat = 9'h1CB;
			STEP_SAC1:  pat = 9'h1C2;
			STEP_SAC2:  pat = 9'h1C6;
			STEP_FLUSH: pat = 9'h006;
			default:    pat = 9'h000;
		endcase
		return pat;
	endfunction

endpackage

// File: design/dpvs_ctrl.sv
// ----------------------------------------------------------------------------
// dpvs_ctrl
// Sequencing state machine: takes one tick, runs the serial rate divider
// when a beat period ends, and hands the result to the output register.
// ----------------------------------------------------------------------------
module dpvs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  dpvs_pkg::dpvs_status_t status,
	output dpvs_pkg::dpvs_cmd_t   cmd
);

	dpvs_pkg::state_t state_q, state_d;
	logic [dpvs_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpvs_pkg::ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			div_cnt_q   <= div_cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		div_cnt_d   = div_cnt_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		in_ready    = 1'b0;

		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;

		case (state_q)
			dpvs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					div_cnt_d  = '0;
					state_d    = status.period_end ? dpvs_pkg::ST_DIV : dpvs_pkg::ST_EMIT;
				end
			end
			dpvs_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + 1'b1;
				if (div_cnt_q == dpvs_pkg::DIV_CNT_W'(dpvs_pkg::DIV_STEPS - 1))
					state_d = dpvs_pkg::ST_EMIT;
			end
			dpvs_pkg::ST_EMIT: begin
				// The output register is free, or its transaction completes now.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = dpvs_pkg::ST_IDLE;
				end
			end
			default: state_d = dpvs_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/dpvs_datapath.sv
// ----------------------------------------------------------------------------
// dpvs_datapath
// Beat counter, the two pump step sequences, configuration registers,
// the restoring rate divider and the output register.
// ----------------------------------------------------------------------------
module dpvs_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dpvs_pkg::dpvs_cmd_t                   cmd,
	output dpvs_pkg::dpvs_status_t                status,
	input  logic                                  cfg_we,
	input  logic [dpvs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpvs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  hold,
	output logic [dpvs_pkg::VALVE_W-1:0]          pump1_valves,
	output logic [dpvs_pkg::VALVE_W-1:0]          pump2_valves,
	output logic [dpvs_pkg::STEP_W-1:0]           pump1_step,
	output logic [dpvs_pkg::STEP_W-1:0]           pump2_step,
	output logic                                  rate_valid,
	output logic [dpvs_pkg::RATE_W-1:0]           measured_rate
);

	localparam int unsigned DW = dpvs_pkg::DIV_W;

	logic [dpvs_pkg::TICK_W-1:0]     beat_period_q;
	logic [dpvs_pkg::HOLD_CNT_W-1:0] eject_ticks_q;
	logic [dpvs_pkg::HOLD_CNT_W-1:0] delay_ticks_q;

	logic [dpvs_pkg::TICK_W-1:0] beat_tick_q;
	dpvs_pkg::pump_t             pump1_q, pump2_q;
	logic [dpvs_pkg::RATE_W-1:0] last_rate_q;
	logic                        end_flag_q;

	logic [DW-1:0] num_q, den_q, quo_q;
	logic [DW:0]   rem_q;

	logic [dpvs_pkg::TICK_W-1:0] tick_nx;
	logic start1, start2, end_now;
	dpvs_pkg::pump_t pump1_nx, pump2_nx;
	logic [DW:0] rem_sh;
	logic        rem_ge;

	function automatic dpvs_pkg::pump_t pump_next(
		input dpvs_pkg::pump_t                   cur,
		input logic                              start,
		input logic [dpvs_pkg::HOLD_CNT_W-1:0]   eject,
		input logic [dpvs_pkg::HOLD_CNT_W-1:0]   delay
	);
		dpvs_pkg::pump_t                 nx;
		logic [dpvs_pkg::STEP_W-1:0]     p;
		logic [dpvs_pkg::HOLD_CNT_W-1:0] lim;
		nx       = cur;
		p        = start ? dpvs_pkg::STEP_FILL : cur.phase;
		nx.phase = p;
		case (p)
			dpvs_pkg::STEP_EJECT: lim = eject;
			dpvs_pkg::STEP_DELAY: lim = delay;
			dpvs_pkg::STEP_FLUSH: lim = dpvs_pkg::FLUSH_STEP_LIMIT;
			default:              lim = dpvs_pkg::SHORT_STEP_LIMIT;
		endcase
		if (p != dpvs_pkg::STEP_IDLE) begin
			nx.pattern = dpvs_pkg::step_pattern(p);
			if (p == dpvs_pkg::STEP_LAST) begin
				nx.count = '0;
				nx.phase = dpvs_pkg::STEP_IDLE;
			end else if (cur.count >= lim) begin
				nx.count = '0;
				nx.phase = p + 1'b1;
			end else begin
				nx.count = cur.count + 1'b1;
			end
		end
		return nx;
	endfunction

	// The counter saturates instead of wrapping.
	assign tick_nx = (&beat_tick_q) ? beat_tick_q : beat_tick_q + 1'b1;
	assign start1  = !hold && (tick_nx == dpvs_pkg::TICK_W'(1));
	assign start2  = !hold && (tick_nx == {1'b0, beat_period_q[dpvs_pkg::TICK_W-1:1]});
	assign end_now = !hold && (tick_nx >= beat_period_q);

	assign pump1_nx = pump_next(pump1_q, start1, eject_ticks_q, delay_ticks_q);
	assign pump2_nx = pump_next(pump2_q, start2, eject_ticks_q, delay_ticks_q);

	assign status.period_end = end_now;

	assign rem_sh = {rem_q[DW-1:0], num_q[DW-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_period_q <= dpvs_pkg::BEAT_PERIOD_RST;
			eject_ticks_q <= dpvs_pkg::EJECT_TICKS_RST;
			delay_ticks_q <= dpvs_pkg::DELAY_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dpvs_pkg::CFG_BEAT_PERIOD: beat_period_q <= cfg_data;
				dpvs_pkg::CFG_EJECT_TICKS:
					eject_ticks_q <= cfg_data[dpvs_pkg::HOLD_CNT_W-1:0];
				dpvs_pkg::CFG_DELAY_TICKS:
					delay_ticks_q <= cfg_data[dpvs_pkg::HOLD_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_tick_q <= '0;
			pump1_q     <= '0;
			pump2_q     <= '0;
			last_rate_q <= '0;
			end_flag_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				beat_tick_q <= end_now ? '0 : tick_nx;
				end_flag_q  <= end_now;
				if (!hold) begin
					pump1_q <= pump1_nx;
					pump2_q <= pump2_nx;
				end
			end
			if (cmd.load_out && end_flag_q)
				last_rate_q <= quo_q[dpvs_pkg::RATE_W-1:0];
		end
	end

	// Restoring division, one quotient bit per step.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			num_q <= dpvs_pkg::RATE_NUM_BASE + {2'b00, tick_nx, 1'b0};
			den_q <= {1'b0, tick_nx, 2'b00} + {3'b000, tick_nx};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[DW-2:0], rem_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pump1_valves  <= pump1_q.pattern;
			pump2_valves  <= pump2_q.pattern;
			pump1_step    <= pump1_q.phase;
			pump2_step    <= pump2_q.phase;
			rate_valid    <= end_flag_q;
			measured_rate <= end_flag_q ? quo_q[dpvs_pkg::RATE_W-1:0] : last_rate_q;
		end
	end

endmodule

// File: design/dual_pump_valve_sequencer.sv
// ----------------------------------------------------------------------------
// dual_pump_valve_sequencer
// Two-pump valve step sequencer driven by scan ticks, with beat rate report.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction (in_valid/in_ready, field hold) is one scan tick.
// Each tick produces exactly one output transaction (out_valid/out_ready)
// carrying both valve patterns, both step numbers, rate_valid and
// measured_rate.
// A tick that does not end a beat period passes from the idle state to the
// emit state, where it is loaded into the output register once that is free,
// and the sequencer then returns to idle for the next tick. A tick that ends a
// period runs the serial rate divider in the divide state, one quotient bit
// per cycle for 19 quotient bits, before it goes on to the emit state.
// One tick is in flight at a time; the output register lets the next tick
// be accepted while the previous result still waits for out_ready.
// If the receiver stalls, the finished result waits in the sequencer and
// in_ready stays low until the output register frees up.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while no tick is in flight.
// Reset clears the beat counter, both sequences and the reported rate and
// loads the default period, eject and delay settings.
// ----------------------------------------------------------------------------
module dual_pump_valve_sequencer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  hold,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [dpvs_pkg::VALVE_W-1:0]          pump1_valves,
	output logic [dpvs_pkg::VALVE_W-1:0]          pump2_valves,
	output logic [dpvs_pkg::STEP_W-1:0]           pump1_step,
	output logic [dpvs_pkg::STEP_W-1:0]           pump2_step,
	output logic                                  rate_valid,
	output logic [dpvs_pkg::RATE_W-1:0]           measured_rate,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dpvs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpvs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	dpvs_pkg::dpvs_cmd_t    cmd;
	dpvs_pkg::dpvs_status_t status;

	assign cfg_ready = 1'b1;

	dpvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dpvs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.hold          (hold),
		.pump1_valves  (pump1_valves),
		.pump2_valves  (pump2_valves),
		.pump1_step    (pump1_step),
		.pump2_step    (pump2_step),
		.rate_valid    (rate_valid),
		.measured_rate (measured_rate)
	);

`ifndef SYNTHESIS
	// Only one tick is in flight: an accepted tick blocks the next one.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("tick accepted while another tick is in flight");

	// A reported rate is always within one to 60000 beats per minute.
	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rate_valid) |->
		(measured_rate != 16'd0 && measured_rate <= 16'd60000))
		else $error("reported rate out of range");

	// An idle pump only follows reset or the final step, so all its valves are off; checked for pump one.
	a_idle_valves_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pump1_step == dpvs_pkg::STEP_IDLE) |-> (pump1_valves == '0))
		else $error("idle pump one has valves open");
`endif

endmodule
